// ===== hw/rtl/dpsc_pkg.sv =====
// Shared types and constants for the dual PWM shared compare unit.
package dpsc_pkg;

  localparam int unsigned TimerWidth = 16;
  localparam int unsigned DataW      = 16;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [DataW-1:0] DelayMask =
    (TimerWidth >= DataW) ? {DataW{1'b1}} : DataW'((64'd1 << TimerWidth) - 64'd1);

  localparam logic [DataW-1:0] PeriodReset = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD = 1'b0,
    REG_INVERT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EDGE_CH1  = 2'd0,
    EDGE_CH2  = 2'd1,
    EDGE_BOTH = 2'd2
  } edge_e;

  typedef struct packed {
    logic             ch1_active;
    logic             ch2_active;
    logic             ch1_full;
    logic             ch2_full;
    edge_e            next_edge;
    logic [DataW-1:0] ch1_latched;
    logic [DataW-1:0] ch2_latched;
    logic             pin1_state;
    logic             pin2_state;
  } pwm_state_t;

  typedef struct packed {
    logic             pin1_level;
    logic             pin2_level;
    logic             compare_update;
    logic [DataW-1:0] next_delay;
  } pwm_result_t;

endpackage

// ===== hw/rtl/dpsc_event.sv =====
// Per-event next-state and result logic of the dual PWM shared compare unit.
module dpsc_event import dpsc_pkg::*; (
  input  pwm_state_t       state_i,
  input  logic [DataW-1:0] duty1_ticks_i,
  input  logic [DataW-1:0] duty2_ticks_i,
  input  logic [DataW-1:0] period_ticks_i,
  input  logic             invert_outputs_i,
  output pwm_state_t       state_o,
  output pwm_result_t      result_o
);

  pwm_state_t       n;
  logic             upd;
  logic [DataW-1:0] delay;

  always_comb begin
    n     = state_i;
    upd   = 1'b1;
    delay = '0;
    if ((!state_i.ch1_active || state_i.ch1_full) &&
        (!state_i.ch2_active || state_i.ch2_full)) begin
      if ((duty1_ticks_i != '0) && !state_i.ch1_full) begin
        n.pin1_state = 1'b1;
        n.ch1_active = 1'b1;
      end
      if ((duty2_ticks_i != '0) && !state_i.ch2_full) begin
        n.pin2_state = 1'b1;
        n.ch2_active = 1'b1;
      end
      if (n.ch1_active && ((duty1_ticks_i <= duty2_ticks_i) || !n.ch2_active)) begin
        delay         = duty1_ticks_i;
        n.ch1_latched = duty1_ticks_i;
        n.ch2_latched = duty2_ticks_i;
        n.next_edge   = (duty1_ticks_i == duty2_ticks_i) ? EDGE_BOTH : EDGE_CH1;
      end else if (n.ch2_active) begin
        delay         = duty2_ticks_i;
        n.ch1_latched = duty1_ticks_i;
        n.ch2_latched = duty2_ticks_i;
        n.next_edge   = EDGE_CH2;
      end else begin
        delay = period_ticks_i;
      end
    end else begin
      case (state_i.next_edge)
        EDGE_CH1: begin
          if (duty1_ticks_i < period_ticks_i) begin
            n.pin1_state = 1'b0;
            n.ch1_active = 1'b0;
            n.ch1_full   = 1'b0;
          end else begin
            n.ch1_full = 1'b1;
          end
          if (state_i.ch2_active) begin
            delay       = state_i.ch2_latched - state_i.ch1_latched;
            n.next_edge = EDGE_CH2;
          end else begin
            delay       = period_ticks_i - state_i.ch1_latched;
            n.next_edge = EDGE_BOTH;
          end
        end
        EDGE_CH2: begin
          if (duty2_ticks_i < period_ticks_i) begin
            n.pin2_state = 1'b0;
            n.ch2_active = 1'b0;
            n.ch2_full   = 1'b0;
          end else begin
            n.ch2_full = 1'b1;
          end
          if (state_i.ch1_active) begin
            delay       = state_i.ch1_latched - state_i.ch2_latched;
            n.next_edge = EDGE_CH1;
          end else begin
            delay       = period_ticks_i - state_i.ch2_latched;
            n.next_edge = EDGE_BOTH;
          end
        end
        default: begin
          upd = 1'b0;
          if (duty1_ticks_i < period_ticks_i) begin
            n.pin1_state = 1'b0;
            n.ch1_active = 1'b0;
            n.ch1_full   = 1'b0;
            delay        = period_ticks_i - state_i.ch1_latched;
            upd          = 1'b1;
          end else begin
            n.ch1_full = 1'b1;
          end
          if (duty2_ticks_i < period_ticks_i) begin
            n.pin2_state = 1'b0;
            n.ch2_active = 1'b0;
            n.ch2_full   = 1'b0;
            delay        = period_ticks_i - state_i.ch2_latched;
            upd          = 1'b1;
          end else begin
            n.ch2_full = 1'b1;
          end
        end
      endcase
    end
  end

  assign state_o                 = n;
  assign result_o.pin1_level     = n.pin1_state ^ invert_outputs_i;
  assign result_o.pin2_level     = n.pin2_state ^ invert_outputs_i;
  assign result_o.compare_update = upd;
  assign result_o.next_delay     = upd ? (delay & DelayMask) : '0;

endmodule

// ===== hw/rtl/dual_pwm_shared_compare_unit.sv =====
// Top level of the dual PWM shared compare unit: registers, handshakes and configuration.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i/in_ready_o   duty1_ticks_i, duty2_ticks_i
//   out       output     out_valid_o/out_ready_i pin1_level_o, pin2_level_o,
//                                                compare_update_o, next_delay_o
//   cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A request is registered on acceptance and its result is registered when the input register
// hands it on, so one request can be accepted every cycle unless the output stalls.
// The channel state advances when the input register hands its request to the result
// register; a stalled output holds the input register and then drops in_ready_o.
// Reset clears the channel state, restores the period to 1000 ticks and drops both valids.
module dual_pwm_shared_compare_unit import dpsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DataW-1:0]   duty1_ticks_i,
  input  logic [DataW-1:0]   duty2_ticks_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               pin1_level_o,
  output logic               pin2_level_o,
  output logic               compare_update_o,
  output logic [DataW-1:0]   next_delay_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i
);

  logic [DataW-1:0] period_q;
  logic             invert_q;

  logic             in_valid_q;
  logic [DataW-1:0] duty1_q;
  logic [DataW-1:0] duty2_q;

  pwm_state_t       state_q, state_d;
  pwm_result_t      result_q, result_d;
  logic             out_valid_q;

  logic             out_free;
  logic             advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PERIOD: period_q <= cfg_wdata_i;
        REG_INVERT: invert_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      duty1_q <= duty1_ticks_i;
      duty2_q <= duty2_ticks_i;
    end
  end

  dpsc_event u_event (
    .state_i          (state_q),
    .duty1_ticks_i    (duty1_q),
    .duty2_ticks_i    (duty2_q),
    .period_ticks_i   (period_q),
    .invert_outputs_i (invert_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{
        ch1_active:  1'b0,
        ch2_active:  1'b0,
        ch1_full:    1'b0,
        ch2_full:    1'b0,
        next_edge:   EDGE_CH1,
        ch1_latched: '0,
        ch2_latched: '0,
        pin1_state:  1'b0,
        pin2_state:  1'b0
      };
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pin1_level_o     = result_q.pin1_level;
  assign pin2_level_o     = result_q.pin2_level;
  assign compare_update_o = result_q.compare_update;
  assign next_delay_o     = result_q.next_delay;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the dual PWM shared compare unit.
`timescale 1ns / 100ps

module testbench;
  import dpsc_pkg::*;

  localparam int QuietLimit = 400;
  localparam int MainRows   = 22;
  localparam int PlanRows   = 25;
  localparam int PhaseCount = 7;
  localparam int PhaseItems = 150;

  typedef struct packed {
    logic [DataW-1:0] d1;
    logic [DataW-1:0] d2;
    logic             typed;
    pwm_result_t      res;
  } duty_row_t;

  // Each row is {duty1, duty2, typed, pin1, pin2, update, delay}. Untyped rows use the predictor.
  // The last three rows drive both channels to full duty, which no event can leave again.
  localparam duty_row_t DutyPlan [0:PlanRows-1] = '{
    {16'd0,     16'd0,     1'b1, 1'b0, 1'b0, 1'b1, 16'd1000},
    {16'd100,   16'd300,   1'b1, 1'b1, 1'b1, 1'b1, 16'd100},
    {16'd100,   16'd300,   1'b1, 1'b0, 1'b1, 1'b1, 16'd200},
    {16'd100,   16'd300,   1'b1, 1'b0, 1'b0, 1'b1, 16'd700},
    {16'd500,   16'd500,   1'b1, 1'b1, 1'b1, 1'b1, 16'd500},
    {16'd500,   16'd500,   1'b1, 1'b0, 1'b0, 1'b1, 16'd500},
    {16'd0,     16'd400,   1'b1, 1'b0, 1'b1, 1'b1, 16'd400},
    {16'd0,     16'd2000,  1'b1, 1'b0, 1'b1, 1'b1, 16'd600},
    {16'd0,     16'd65535, 1'b1, 1'b0, 1'b1, 1'b1, 16'd65535},
    {16'd65535, 16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 16'd0},
    {16'd65535, 16'd0,     1'b1, 1'b1, 1'b0, 1'b1, 16'd65535},
    {16'd65535, 16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    {16'd1000,  16'd1000,  1'b1, 1'b1, 1'b1, 1'b1, 16'd1000},
    {16'd999,   16'd5000,  1'b1, 1'b0, 1'b1, 1'b1, 16'd0},
    {16'd999,   16'd3000,  1'b1, 1'b1, 1'b1, 1'b1, 16'd999},
    {16'd999,   16'd3000,  1'b1, 1'b0, 1'b1, 1'b1, 16'd2001},
    {16'd999,   16'd1,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    {16'd1,     16'd0,     1'b1, 1'b1, 1'b0, 1'b1, 16'd998},
    {16'd1,     16'd0,     1'b1, 1'b0, 1'b0, 1'b1, 16'd1},
    {16'hAAAA,  16'h5555,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    {16'hAAAA,  16'h5555,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    {16'd0,     16'h5555,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    {16'd65535, 16'd65535, 1'b1, 1'b1, 1'b1, 1'b1, 16'd65535},
    {16'd65535, 16'd65535, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0},
    {16'd65535, 16'd65535, 1'b1, 1'b1, 1'b1, 1'b1, 16'd65535}
  };

  logic               clk;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [DataW-1:0]   duty1_ticks_i;
  logic [DataW-1:0]   duty2_ticks_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               pin1_level_o;
  logic               pin2_level_o;
  logic               compare_update_o;
  logic [DataW-1:0]   next_delay_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_wdata_i;

  pwm_result_t        predicted_events [$];
  pwm_state_t         chan;
  logic [DataW-1:0]   period_cfg;
  logic               invert_cfg;
  bit                 calm;
  int                 stall_left;
  int                 quiet_cycles;
  int                 mismatches;

  dual_pwm_shared_compare_unit uut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .duty1_ticks_i    (duty1_ticks_i),
    .duty2_ticks_i    (duty2_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pin1_level_o     (pin1_level_o),
    .pin2_level_o     (pin2_level_o),
    .compare_update_o (compare_update_o),
    .next_delay_o     (next_delay_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pwm_result_t next_compare(inout pwm_state_t s,
                                               input logic [DataW-1:0] d1,
                                               input logic [DataW-1:0] d2);
    pwm_result_t      r;
    logic [DataW-1:0] dly;
    logic             upd;
    dly = '0;
    upd = 1'b1;
    if ((!s.ch1_active || s.ch1_full) && (!s.ch2_active || s.ch2_full)) begin
      if (d1 != '0 && !s.ch1_full) begin
        s.pin1_state = 1'b1;
        s.ch1_active = 1'b1;
      end
      if (d2 != '0 && !s.ch2_full) begin
        s.pin2_state = 1'b1;
        s.ch2_active = 1'b1;
      end
      if (s.ch1_active && (d1 <= d2 || !s.ch2_active)) begin
        dly = d1;
        s.ch1_latched = d1;
        s.ch2_latched = d2;
        s.next_edge = (d1 == d2) ? EDGE_BOTH : EDGE_CH1;
      end else if (s.ch2_active) begin
        dly = d2;
        s.ch1_latched = d1;
        s.ch2_latched = d2;
        s.next_edge = EDGE_CH2;
      end else begin
        dly = period_cfg;
      end
    end else if (s.next_edge == EDGE_CH1) begin
      if (d1 < period_cfg) begin
        s.pin1_state = 1'b0;
        s.ch1_active = 1'b0;
        s.ch1_full = 1'b0;
      end else begin
        s.ch1_full = 1'b1;
      end
      if (s.ch2_active) begin
        dly = s.ch2_latched - s.ch1_latched;
        s.next_edge = EDGE_CH2;
      end else begin
        dly = period_cfg - s.ch1_latched;
        s.next_edge = EDGE_BOTH;
      end
    end else if (s.next_edge == EDGE_CH2) begin
      if (d2 < period_cfg) begin
        s.pin2_state = 1'b0;
        s.ch2_active = 1'b0;
        s.ch2_full = 1'b0;
      end else begin
        s.ch2_full = 1'b1;
      end
      if (s.ch1_active) begin
        dly = s.ch1_latched - s.ch2_latched;
        s.next_edge = EDGE_CH1;
      end else begin
        dly = period_cfg - s.ch2_latched;
        s.next_edge = EDGE_BOTH;
      end
    end else begin
      upd = 1'b0;
      if (d1 < period_cfg) begin
        s.pin1_state = 1'b0;
        s.ch1_active = 1'b0;
        s.ch1_full = 1'b0;
        dly = period_cfg - s.ch1_latched;
        upd = 1'b1;
      end else begin
        s.ch1_full = 1'b1;
      end
      if (d2 < period_cfg) begin
        s.pin2_state = 1'b0;
        s.ch2_active = 1'b0;
        s.ch2_full = 1'b0;
        dly = period_cfg - s.ch2_latched;
        upd = 1'b1;
      end else begin
        s.ch2_full = 1'b1;
      end
    end
    dly = dly & DelayMask;
    if (!upd) begin
      dly = '0;
    end
    r.pin1_level = s.pin1_state ^ invert_cfg;
    r.pin2_level = s.pin2_state ^ invert_cfg;
    r.compare_update = upd;
    r.next_delay = dly;
    return r;
  endfunction

  function automatic logic [DataW-1:0] pick_duty();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return period_cfg;
      2: return period_cfg - 1'b1;
      3: return '1;
      4, 5, 6, 7: return DataW'($urandom_range(1, period_cfg));
      8: return DataW'($urandom_range(period_cfg, 16'hFFFF));
      default: return DataW'($urandom());
    endcase
  endfunction

  task automatic send_duties(input logic [DataW-1:0] d1, input logic [DataW-1:0] d2,
                             input pwm_result_t want);
    predicted_events.push_back(want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    duty1_ticks_i <= d1;
    duty2_ticks_i <= d2;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_PERIOD) begin
      period_cfg = val;
    end else begin
      invert_cfg = val[0];
    end
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (predicted_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    pwm_result_t want;
    pwm_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {pin1_level_o, pin2_level_o, compare_update_o, next_delay_o};
      if (predicted_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result pins %b%b update %b delay %0d", $time,
                 got.pin1_level, got.pin2_level, got.compare_update, got.next_delay);
      end else begin
        want = predicted_events.pop_front();
        if (got.pin1_level !== want.pin1_level || got.pin2_level !== want.pin2_level ||
            got.compare_update !== want.compare_update ||
            got.next_delay !== want.next_delay) begin
          mismatches++;
          $display("%0t: expected pins %b%b update %b delay %0d, got pins %b%b update %b delay %0d",
                   $time, want.pin1_level, want.pin2_level, want.compare_update,
                   want.next_delay, got.pin1_level, got.pin2_level, got.compare_update,
                   got.next_delay);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    pwm_result_t      want;
    pwm_state_t       trial;
    logic [DataW-1:0] d1;
    logic [DataW-1:0] d2;
    logic [DataW-1:0] per;
    logic             inv;
    int               tries;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    duty1_ticks_i = '0;
    duty2_ticks_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PERIOD;
    cfg_wdata_i = '0;
    chan = '0;
    period_cfg = PeriodReset;
    invert_cfg = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    repeat (8) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < MainRows; i++) begin
      want = next_compare(chan, DutyPlan[i].d1, DutyPlan[i].d2);
      send_duties(DutyPlan[i].d1, DutyPlan[i].d2, DutyPlan[i].typed ? DutyPlan[i].res : want);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      drain_requests();
      case (p)
        0: begin
          per = 16'd1;
          inv = 1'b1;
        end
        1: begin
          per = 16'hFFFF;
          inv = 1'b0;
        end
        2: begin
          per = PeriodReset;
          inv = 1'b1;
        end
        3: begin
          per = DataW'($urandom_range(2, 400));
          inv = 1'($urandom_range(0, 1));
        end
        4: begin
          per = DataW'($urandom_range(1, 16'hFFFF));
          inv = 1'($urandom_range(0, 1));
        end
        5: begin
          per = 16'd2;
          inv = 1'b0;
        end
        default: begin
          per = DataW'($urandom_range(50, 3000));
          inv = 1'b0;
        end
      endcase
      write_reg(REG_PERIOD, per);
      write_reg(REG_INVERT, {{(DataW-1){1'b0}}, inv});
      cfg_we_i <= 1'b0;
      calm = (p == PhaseCount - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        // Both channels at full duty is a state no event leaves, so it is kept for the end.
        tries = 0;
        do begin
          d1 = pick_duty();
          d2 = ($urandom_range(0, 3) == 0) ? d1 : pick_duty();
          trial = chan;
          void'(next_compare(trial, d1, d2));
          tries++;
        end while (trial.ch1_full && trial.ch2_full && tries < 8);
        if (trial.ch1_full && trial.ch2_full) begin
          d1 = '0;
          d2 = '0;
        end
        want = next_compare(chan, d1, d2);
        send_duties(d1, d2, want);
      end
    end

    for (int k = 0; k < 8 && (chan.ch1_active || chan.ch2_active); k++) begin
      want = next_compare(chan, 16'd1, 16'd1);
      send_duties(16'd1, 16'd1, want);
    end
    for (int i = MainRows; i < PlanRows; i++) begin
      want = next_compare(chan, DutyPlan[i].d1, DutyPlan[i].d2);
      send_duties(DutyPlan[i].d1, DutyPlan[i].d2, DutyPlan[i].typed ? DutyPlan[i].res : want);
    end

    in_valid_i <= 1'b0;
    while (predicted_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
